### hw/rtl/rtn_pkg.sv
// Shared types and constants for the RGB to NV12 converter.
package rtn_pkg;

  // Component and sum widths
  localparam int COMP_W = 8;
  localparam int POS_W  = 12;
  localparam int DIM_W  = 13;
  localparam int SUM_W  = 9;   // sum of two components
  localparam int BLK_W  = 10;  // sum of four components
  localparam int LINE_W = 3 * SUM_W;

  // Configuration register indexes
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_FRAME_WIDTH  = 1'd0;
  localparam cfg_index_t CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd1080;
  localparam int MAX_HEIGHT = 4096;

  // BT.601 luma coefficients
  localparam int Y_R   = 66;
  localparam int Y_G   = 129;
  localparam int Y_B   = 25;
  localparam int Y_RND = 128;
  localparam int Y_OFS = 16;

  // Chroma coefficient magnitudes; block sums fold in the divide by four
  localparam int U_R   = 38;
  localparam int U_G   = 74;
  localparam int U_B   = 112;
  localparam int V_R   = 112;
  localparam int V_G   = 94;
  localparam int V_B   = 18;
  localparam int C_OFS = 512 + (128 << 10);

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [COMP_W-1:0] blue;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic              is_chroma;
    logic [COMP_W-1:0] luma;
    logic [COMP_W-1:0] chroma_u;
    logic [COMP_W-1:0] chroma_v;
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
    logic              end_of_frame;
    logic              last;
  } result_t;

  // Classified pixel passed from front to back
  typedef struct packed {
    pixel_t            pix;
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
    logic              need_chroma;
    logic              eof;
    logic [BLK_W-1:0]  sum_b;
    logic [BLK_W-1:0]  sum_g;
    logic [BLK_W-1:0]  sum_r;
  } item_t;

endpackage

### hw/rtl/rtn_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module rtn_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 2048,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/rtn_front.sv
// Front end: accepts pixels, tracks position, builds pair and block sums.
module rtn_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rtn_pkg::DIM_W-1:0] frame_width,
  input  logic [rtn_pkg::DIM_W-1:0] frame_height,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rtn_pkg::pixel_t           in_data,
  output logic                      q_valid,
  input  logic                      q_ready,
  output rtn_pkg::item_t            q_item
);

  localparam int LineDepth = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int LineAddrW = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam int MaxWEven  = MAX_WIDTH & ~1;
  localparam int CntW      = rtn_pkg::DIM_W + 1;
  localparam int PW        = rtn_pkg::POS_W;
  localparam int SW        = rtn_pkg::SUM_W;

  logic [PW-1:0]         col_r, col_nxt;
  logic [PW-1:0]         row_r, row_nxt;
  rtn_pkg::pixel_t       left_r, left_nxt;
  logic                  s1_valid_r, s1_valid_nxt;
  rtn_pkg::pixel_t       s1_pix_r;
  logic [PW-1:0]         s1_col_r, s1_row_r;
  logic                  s1_need_r, s1_eof_r;
  logic [SW-1:0]         s1_sb_r, s1_sg_r, s1_sr_r;

  logic                  accept;
  logic [CntW-1:0]       w_up, h_up, w_eff, h_eff;
  logic [CntW-1:0]       col_inc, row_inc;
  logic                  col_wrap, row_wrap;
  logic [SW-1:0]         pair_b, pair_g, pair_r;
  logic [PW-1:0]         col_half;
  logic [LineAddrW-1:0]  line_addr;
  logic                  line_wr, line_rd;
  logic [rtn_pkg::LINE_W-1:0] line_q;

  // Stage register frees up whenever the queue takes its word
  assign in_stall = s1_valid_r && !q_ready;
  assign accept   = in_valid && !in_stall;

  // Effective frame size: rounded up to even, clamped
  always_comb begin
    w_up = ({1'b0, frame_width} + CntW'(1)) & ~CntW'(1);
    h_up = ({1'b0, frame_height} + CntW'(1)) & ~CntW'(1);
    w_eff = w_up;
    if (w_up < CntW'(2)) begin
      w_eff = CntW'(2);
    end else if (w_up > CntW'(MaxWEven)) begin
      w_eff = CntW'(MaxWEven);
    end
    h_eff = h_up;
    if (h_up < CntW'(2)) begin
      h_eff = CntW'(2);
    end else if (h_up > CntW'(rtn_pkg::MAX_HEIGHT)) begin
      h_eff = CntW'(rtn_pkg::MAX_HEIGHT);
    end
  end

  // Raster position
  assign col_inc  = CntW'(col_r) + CntW'(1);
  assign row_inc  = CntW'(row_r) + CntW'(1);
  assign col_wrap = col_inc >= w_eff;
  assign row_wrap = row_inc >= h_eff;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_inc[PW-1:0];
      end else begin
        col_nxt = col_inc[PW-1:0];
      end
      if (!col_r[0]) begin
        left_nxt = in_data;
      end
    end
  end

  // Horizontal pair sums
  assign pair_b = SW'(in_data.blue)  + SW'(left_r.blue);
  assign pair_g = SW'(in_data.green) + SW'(left_r.green);
  assign pair_r = SW'(in_data.red)   + SW'(left_r.red);

  // Column stays below the line width, so x/2 fits the line without wrap
  assign col_half  = {1'b0, col_r[PW-1:1]};
  assign line_addr = col_half[LineAddrW-1:0];
  assign line_wr   = accept && col_r[0] && !row_r[0];
  assign line_rd   = accept && col_r[0] && row_r[0];

  rtn_ram #(
    .WIDTH (rtn_pkg::LINE_W),
    .DEPTH (LineDepth)
  ) u_line (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (line_addr),
    .wr_data ({pair_r, pair_g, pair_b}),
    .rd_en   (line_rd),
    .rd_addr (line_addr),
    .rd_data (line_q)
  );

  assign s1_valid_nxt = in_stall ? s1_valid_r : accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      left_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      left_r     <= left_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Stage payload; the line read lands alongside it
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_data;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_need_r <= col_r[0] && row_r[0];
      s1_eof_r  <= col_wrap && row_wrap;
      s1_sb_r   <= pair_b;
      s1_sg_r   <= pair_g;
      s1_sr_r   <= pair_r;
    end
  end

  // Block sums: this row's pair plus the stored pair from the row above
  always_comb begin
    q_item             = '0;
    q_item.pix         = s1_pix_r;
    q_item.column      = s1_col_r;
    q_item.row         = s1_row_r;
    q_item.need_chroma = s1_need_r;
    q_item.eof         = s1_eof_r;
    q_item.sum_b = rtn_pkg::BLK_W'(s1_sb_r) + rtn_pkg::BLK_W'(line_q[SW-1:0]);
    q_item.sum_g = rtn_pkg::BLK_W'(s1_sg_r) + rtn_pkg::BLK_W'(line_q[2*SW-1:SW]);
    q_item.sum_r = rtn_pkg::BLK_W'(s1_sr_r) + rtn_pkg::BLK_W'(line_q[3*SW-1:2*SW]);
  end

  assign q_valid = s1_valid_r;

  // Line reads happen only on the right pixel of an odd-row pair
  a_rd_pos: assert property (@(posedge clk) disable iff (!rst_n)
    line_rd |=> s1_valid_r && s1_need_r)
    else $error("line read without chroma item");

  // Never read and write the line store for the same pixel
  a_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(line_rd && line_wr))
    else $error("line read and write together");

endmodule

### hw/rtl/rtn_fifo.sv
// Short queue of classified pixels between front and back.
module rtn_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rtn_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rtn_pkg::item_t pop_item
);

  localparam int Depth = rtn_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  rtn_pkg::item_t  mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = cnt_r != CntW'(Depth);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Occupancy stays within the queue
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Depth))
    else $error("queue overflow");

endmodule

### hw/rtl/rtn_back.sv
// Back end: color math and emission of luma and chroma words.
module rtn_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  rtn_pkg::item_t    q_item,
  output logic              out_valid,
  input  logic              out_stall,
  output rtn_pkg::result_t  out_data
);

  localparam int PW = rtn_pkg::POS_W;
  localparam int CW = rtn_pkg::COMP_W;

  // Product stage
  logic           p_valid_r, p_valid_nxt;
  logic [16:0]    p_y_r;
  logic [17:0]    p_upos_r, p_vpos_r;
  logic [16:0]    p_uneg_r, p_vneg_r;
  logic [PW-1:0]  p_col_r, p_row_r;
  logic           p_need_r, p_eof_r;

  // Emit stage
  logic           e_valid_r, e_valid_nxt;
  logic           e_phase_r, e_phase_nxt;
  logic [CW-1:0]  e_y_r, e_u_r, e_v_r;
  logic [PW-1:0]  e_col_r, e_row_r;
  logic           e_need_r, e_eof_r;

  logic             out_valid_r, out_valid_nxt;
  rtn_pkg::result_t out_data_r, res;

  logic           o_free, e_emit, e_done, e_take;
  logic [8:0]     y9;
  logic [17:0]    u_diff, v_diff;

  // Flow control back to front
  assign o_free  = !out_valid_r || !out_stall;
  assign e_emit  = e_valid_r && o_free;
  assign e_done  = e_emit && (e_phase_r || !e_need_r);
  assign e_take  = !e_valid_r || e_done;
  assign q_ready = !p_valid_r || e_take;

  assign p_valid_nxt   = q_ready ? q_valid : p_valid_r;
  assign out_valid_nxt = o_free ? e_valid_r : out_valid_r;

  always_comb begin
    e_valid_nxt = e_valid_r;
    e_phase_nxt = e_phase_r;
    if (e_take) begin
      e_valid_nxt = p_valid_r;
      e_phase_nxt = 1'b0;
    end else if (e_emit) begin
      e_phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      e_phase_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r   <= p_valid_nxt;
      e_valid_r   <= e_valid_nxt;
      e_phase_r   <= e_phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Constant-coefficient products
  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      p_y_r <= 17'(rtn_pkg::Y_R) * 17'(q_item.pix.red)
             + 17'(rtn_pkg::Y_G) * 17'(q_item.pix.green)
             + 17'(rtn_pkg::Y_B) * 17'(q_item.pix.blue)
             + 17'(rtn_pkg::Y_RND);
      p_upos_r <= 18'(rtn_pkg::U_B) * 18'(q_item.sum_b) + 18'(rtn_pkg::C_OFS);
      p_uneg_r <= 17'(rtn_pkg::U_R) * 17'(q_item.sum_r)
                + 17'(rtn_pkg::U_G) * 17'(q_item.sum_g);
      p_vpos_r <= 18'(rtn_pkg::V_R) * 18'(q_item.sum_r) + 18'(rtn_pkg::C_OFS);
      p_vneg_r <= 17'(rtn_pkg::V_G) * 17'(q_item.sum_g)
                + 17'(rtn_pkg::V_B) * 17'(q_item.sum_b);
      p_col_r  <= q_item.column;
      p_row_r  <= q_item.row;
      p_need_r <= q_item.need_chroma;
      p_eof_r  <= q_item.eof;
    end
  end

  // Final sums, scaling and clamping; chroma numerators never go negative
  assign y9     = 9'(p_y_r[16:8]) + 9'(rtn_pkg::Y_OFS);
  assign u_diff = p_upos_r - {1'b0, p_uneg_r};
  assign v_diff = p_vpos_r - {1'b0, p_vneg_r};

  always_ff @(posedge clk) begin
    if (e_take && p_valid_r) begin
      e_y_r    <= y9[8] ? 8'hFF : y9[7:0];
      e_u_r    <= u_diff[17:10];
      e_v_r    <= v_diff[17:10];
      e_col_r  <= p_col_r;
      e_row_r  <= p_row_r;
      e_need_r <= p_need_r;
      e_eof_r  <= p_eof_r;
    end
  end

  // Luma word first, then the chroma word when the pair closes a block
  always_comb begin
    res = '0;
    if (e_phase_r) begin
      res.is_chroma    = 1'b1;
      res.chroma_u     = e_u_r;
      res.chroma_v     = e_v_r;
      res.column       = {1'b0, e_col_r[PW-1:1]};
      res.row          = {1'b0, e_row_r[PW-1:1]};
      res.end_of_frame = e_eof_r;
      res.last         = 1'b1;
    end else begin
      res.luma         = e_y_r;
      res.column       = e_col_r;
      res.row          = e_row_r;
      res.end_of_frame = e_eof_r && !e_need_r;
      res.last         = !e_need_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e_emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A luma word that is not last is followed at once by its chroma word
  a_chroma_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !out_data_r.last
    |=> out_valid_r && out_data_r.is_chroma)
    else $error("chroma word missing after luma");

  // A chroma word always closes its pixel
  a_chroma_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.is_chroma |-> out_data_r.last)
    else $error("chroma word not last");

endmodule

### hw/rtl/rgb_to_nv12_converter.sv
// Channel   Direction  Handshake           Word
// in_       input      in_valid/in_stall   rtn_pkg::pixel_t (blue, green, red)
// out_      output     out_valid/out_stall rtn_pkg::result_t
// cfg_      input      cfg_valid/cfg_ready index 0 frame_width, 1 frame_height
//
// A pixel that causes only a luma word yields one word; one that closes a 2x2
// block yields a luma then a chroma word, one word per cycle while out_stall
// is low. Pixels pass the front stage register, the queue, the product and
// emit stages and the result register. Synchronous active-low reset clears
// counters and pipeline; the line RAM is not cleared. An output stall backs
// up through a 4-word queue before the input stalls. cfg_ready is always high.
module rgb_to_nv12_converter #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rtn_pkg::pixel_t           in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rtn_pkg::result_t          out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  rtn_pkg::cfg_index_t       cfg_index,
  input  logic [rtn_pkg::DIM_W-1:0] cfg_data
);

  logic [rtn_pkg::DIM_W-1:0] frame_width_r, frame_width_nxt;
  logic [rtn_pkg::DIM_W-1:0] frame_height_r, frame_height_nxt;
  logic                      fq_valid, fq_ready;
  rtn_pkg::item_t            fq_item;
  logic                      bq_valid, bq_ready;
  rtn_pkg::item_t            bq_item;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rtn_pkg::CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_data;
        rtn_pkg::CFG_FRAME_HEIGHT: frame_height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= rtn_pkg::RESET_WIDTH;
      frame_height_r <= rtn_pkg::RESET_HEIGHT;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  rtn_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_item       (fq_item)
  );

  rtn_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_item   (bq_item)
  );

  rtn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_item    (bq_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 200;
  localparam int SIZE_LIMIT  = 4096;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  rtn_pkg::pixel_t             in_data;
  logic                        out_valid;
  logic                        out_stall;
  rtn_pkg::result_t            out_data;
  logic                        cfg_valid;
  logic                        cfg_ready;
  rtn_pkg::cfg_index_t         cfg_index;
  logic [rtn_pkg::DIM_W-1:0]   cfg_data;

  // Predicted converter state
  logic [rtn_pkg::DIM_W-1:0]   frame_w;
  logic [rtn_pkg::DIM_W-1:0]   frame_h;
  int                          col_pos;
  int                          row_pos;
  rtn_pkg::pixel_t             left_pix;
  logic [rtn_pkg::LINE_W-1:0]  pair_sums [SIZE_LIMIT/2];
  rtn_pkg::result_t            nv12_expected [$];

  // Idling control and bookkeeping
  int send_idle_pct;
  int recv_idle_pct;
  bit long_hold_req;
  int n_errors;
  int n_pixels;
  int n_luma;
  int n_chroma;
  int n_settings;
  int n_cycles;

  rgb_to_nv12_converter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words still expected", $time, nv12_expected.size());
      $display("rgb_to_nv12_converter test failed");
      $finish;
    end
  end

  // Size actually used: rounded up to even, clamped to 2..hi
  function automatic int even_size(input logic [rtn_pkg::DIM_W-1:0] v, input int hi);
    int s;
    s = (int'(v) + 1) & ~1;
    if (s < 2) s = 2;
    if (s > hi) s = hi;
    return s;
  endfunction

  function automatic logic [7:0] clip8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  // Works out the words one pixel causes and advances the position
  task automatic predict_nv12(input rtn_pkg::pixel_t p);
    int               wd, ht, x, y, idx;
    int               b, g, r, sb, sg, sr, tb, tg, tr, un, vn;
    rtn_pkg::result_t lw, cw;
    bit               chroma, eof;
    wd = even_size(frame_w, SIZE_LIMIT);
    ht = even_size(frame_h, SIZE_LIMIT);
    x = col_pos;
    y = row_pos;
    idx = x >> 1;
    b = int'(p.blue);
    g = int'(p.green);
    r = int'(p.red);
    chroma = 1'b0;

    lw = '0;
    lw.luma = clip8(((66 * r + 129 * g + 25 * b + 128) >> 8) + 16);
    lw.column = 12'(x);
    lw.row = 12'(y);

    if ((x & 1) == 0) begin
      left_pix = p;
    end else begin
      sb = b + int'(left_pix.blue);
      sg = g + int'(left_pix.green);
      sr = r + int'(left_pix.red);
      if ((y & 1) == 0) begin
        // even row: keep pair sums for the row below
        pair_sums[idx] = {9'(sr), 9'(sg), 9'(sb)};
      end else begin
        // odd row: 2x2 block sums, coefficients already divided by four
        tb = sb + int'(pair_sums[idx][8:0]);
        tg = sg + int'(pair_sums[idx][17:9]);
        tr = sr + int'(pair_sums[idx][26:18]);
        un = -38 * tr - 74 * tg + 112 * tb + 512 + (128 << 10);
        vn = 112 * tr - 94 * tg - 18 * tb + 512 + (128 << 10);
        cw = '0;
        cw.is_chroma = 1'b1;
        cw.chroma_u = clip8(un >>> 10);
        cw.chroma_v = clip8(vn >>> 10);
        cw.column = 12'(x >> 1);
        cw.row = 12'(y >> 1);
        chroma = 1'b1;
      end
    end

    // position wraps once the next one reaches or passes the size
    eof = 1'b0;
    if (x + 1 >= wd) begin
      col_pos = 0;
      if (y + 1 >= ht) begin
        row_pos = 0;
        eof = 1'b1;
      end else begin
        row_pos = (y + 1) & 'hFFF;
      end
    end else begin
      col_pos = (x + 1) & 'hFFF;
    end

    if (chroma) begin
      cw.end_of_frame = eof;
      cw.last = 1'b1;
      nv12_expected.push_back(lw);
      nv12_expected.push_back(cw);
    end else begin
      lw.end_of_frame = eof;
      lw.last = 1'b1;
      nv12_expected.push_back(lw);
    end
  endtask

  // Sends one pixel word, with random idle cycles ahead of it
  task automatic send_pixel(input rtn_pkg::pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    predict_nv12(p);
    n_pixels++;
  endtask

  // Components lean toward the extremes now and then
  function automatic logic [7:0] rand_comp();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_pixels(input int count);
    rtn_pkg::pixel_t p;
    for (int i = 0; i < count; i++) begin
      p.blue = rand_comp();
      p.green = rand_comp();
      p.red = rand_comp();
      send_pixel(p);
    end
  endtask

  // Every pixel yields a word, so an empty queue means the block is idle
  task automatic drain_words();
    in_valid <= 1'b0;
    while (nv12_expected.size() != 0) @(posedge clk);
  endtask

  task automatic set_frame_size(input int w, input int h);
    drain_words();
    cfg_valid <= 1'b1;
    cfg_index <= rtn_pkg::CFG_FRAME_WIDTH;
    cfg_data <= rtn_pkg::DIM_W'(w);
    do @(posedge clk); while (!cfg_ready);
    frame_w = rtn_pkg::DIM_W'(w);
    cfg_index <= rtn_pkg::CFG_FRAME_HEIGHT;
    cfg_data <= rtn_pkg::DIM_W'(h);
    do @(posedge clk); while (!cfg_ready);
    frame_h = rtn_pkg::DIM_W'(h);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic set_idling(input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
  endtask

  // Black, white and pure blue blocks, then alternating bit patterns
  task automatic test_pixel_extremes();
    rtn_pkg::pixel_t p;
    set_idling(33, 59);
    set_frame_size(8, 2);
    for (int i = 0; i < 16; i++) begin
      case ((i % 8) >> 1)
        0: p = '{blue: 8'h00, green: 8'h00, red: 8'h00};
        1: p = '{blue: 8'hFF, green: 8'hFF, red: 8'hFF};
        2: p = '{blue: 8'hFF, green: 8'h00, red: 8'h00};
        default: begin
          if (i & 1) p = '{blue: 8'h55, green: 8'hAA, red: 8'h55};
          else p = '{blue: 8'hAA, green: 8'h55, red: 8'hAA};
        end
      endcase
      send_pixel(p);
    end
  endtask

  // Width 1 and height 0 both round up to 2
  task automatic test_odd_sizes();
    set_frame_size(1, 0);
    send_random_pixels(4);
  endtask

  // Size shrinks under the current position: column, then row, wrap at once
  task automatic test_midframe_shrink();
    set_frame_size(4, 4);
    send_random_pixels(6);
    set_frame_size(2, 2);
    send_random_pixels(1);
    set_frame_size(4, 4);
    send_random_pixels(8);
    set_frame_size(4, 2);
    send_random_pixels(4);
  endtask

  // Long output hold while pixels keep coming, so the input stalls
  task automatic test_output_backpressure();
    set_frame_size(8, 4);
    long_hold_req = 1'b1;
    send_random_pixels(32);
  endtask

  // Oversized width and height; the start of the long first row also fills
  // every line entry that the small random frames can reach later
  task automatic test_max_sizes();
    set_frame_size(8191, 4097);
    send_random_pixels(16);
  endtask

  // Mostly whole small frames; a few odd sizes and cut-short frames
  task automatic test_random_frames(input int n_items, input int s_pct, input int r_pct);
    int sent, wcfg, hcfg, count;
    sent = 0;
    set_idling(s_pct, r_pct);
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) wcfg = $urandom_range(0, 15);
      else wcfg = 2 * $urandom_range(1, 6);
      if ($urandom_range(9) == 0) hcfg = $urandom_range(0, 7);
      else hcfg = 2 * $urandom_range(1, 3);
      set_frame_size(wcfg, hcfg);
      count = even_size(rtn_pkg::DIM_W'(wcfg), SIZE_LIMIT)
            * even_size(rtn_pkg::DIM_W'(hcfg), SIZE_LIMIT);
      // a cut-short frame leaves the next size change mid-frame
      if ($urandom_range(7) == 0) count = $urandom_range(1, count - 1);
      send_random_pixels(count);
      sent += count;
    end
  endtask

  // Receiver: random stall, or a long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic int diff_field(input string name, input logic [11:0] want,
                                    input logic [11:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin : check_nv12
    rtn_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (nv12_expected.size() == 0) begin
        $display("%0t: word with nothing expected, actual %h", $time, out_data);
        n_errors++;
      end else begin
        want = nv12_expected.pop_front();
        n_errors += diff_field("is_chroma", 12'(want.is_chroma), 12'(out_data.is_chroma));
        n_errors += diff_field("luma", 12'(want.luma), 12'(out_data.luma));
        n_errors += diff_field("chroma_u", 12'(want.chroma_u), 12'(out_data.chroma_u));
        n_errors += diff_field("chroma_v", 12'(want.chroma_v), 12'(out_data.chroma_v));
        n_errors += diff_field("column", want.column, out_data.column);
        n_errors += diff_field("row", want.row, out_data.row);
        n_errors += diff_field("end_of_frame", 12'(want.end_of_frame),
                               12'(out_data.end_of_frame));
        n_errors += diff_field("last", 12'(want.last), 12'(out_data.last));
        if (want.is_chroma) n_chroma++;
        else n_luma++;
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = rtn_pkg::CFG_FRAME_WIDTH;
    cfg_data = '0;
    rst_n = 1'b0;
    frame_w = 13'd1920;
    frame_h = 13'd1080;
    col_pos = 0;
    row_pos = 0;
    left_pix = '0;
    long_hold_req = 1'b0;
    n_errors = 0;
    n_pixels = 0;
    n_luma = 0;
    n_chroma = 0;
    n_settings = 0;
    n_cycles = 0;
    set_idling(0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pixel_extremes();
    test_odd_sizes();
    test_midframe_shrink();
    test_output_backpressure();
    test_max_sizes();
    test_random_frames(105, 33, 59);
    test_random_frames(105, 59, 33);
    test_random_frames(105, 0, 0);

    // let any stray word show up before the verdict
    drain_words();
    repeat (20) @(posedge clk);

    $display("Sent %0d pixels; checked %0d luma and %0d chroma words over %0d frame sizes.",
             n_pixels, n_luma, n_chroma, n_settings);
    $display("Included odd, zero and oversized sizes, mid-frame shrink and a long output hold.");
    if (n_errors == 0) begin
      $display("rgb_to_nv12_converter test passed");
    end else begin
      $display("rgb_to_nv12_converter test failed");
    end
    $finish;
  end

endmodule
